// ===== rtl/core/erhs_pkg.sv =====
// ----------------------------------------------------------------------------
// erhs_pkg: shared types and constants for the exclusion ring hop step
// Item layouts, codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package erhs_pkg;

  localparam int MAX_SITES_DEF     = 128;
  localparam int MAX_PARTICLES_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 7;
  localparam int TRAP_W   = 32;
  localparam int VAR_W    = 16;
  localparam int CLOCK_W  = 48;
  localparam int TALLY_W  = 32;
  localparam int CHOSEN_W = 4;
  localparam int POS_W    = 7;
  localparam int WAIT_W   = 40;
  localparam int PROD_W   = TRAP_W + VAR_W;
  localparam int VAR_FRAC = 12;
  localparam int ALU_W    = CLOCK_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int RING_W     = 8;
  localparam int PCOUNT_W   = 5;

  localparam logic [RING_W-1:0]   RING_SIZE_RST = 8'd100;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RST    = 5'd10;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'd1;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  localparam logic signed [TALLY_W-1:0] TALLY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TALLY_W-1:0] TALLY_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [TRAP_W-1:0]  trap_value;
    logic               direction;
    logic [VAR_W-1:0]   variate;
  } in_item_t;

  typedef struct packed {
    logic [CLOCK_W-1:0]        elapsed_time;
    logic signed [TALLY_W-1:0] net_current;
    logic [CHOSEN_W-1:0]       chosen_particle;
    logic [POS_W-1:0]          new_position;
    logic                      hopped;
  } out_item_t;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN,
    ST_CLK,
    ST_SUB,
    ST_POS,
    ST_HOP,
    ST_TRAP,
    ST_MUL,
    ST_WRW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              accept;
    logic [KIND_W-1:0] kind;
    logic              seed_ok;
    logic              cnt_last;
    logic              out_free;
  } stat_t;

  typedef struct packed {
    logic ready;
    logic min_en;
    logic clk_en;
    logic sub_en;
    logic pos_en;
    logic hop_en;
    logic trap_rd;
    logic mul_en;
    logic wr_en;
    logic out_load;
  } ctrl_t;

endpackage

// ===== rtl/core/erhs_chan_if.sv =====
// ----------------------------------------------------------------------------
// erhs_chan_if: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface erhs_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/erhs_alu.sv =====
// ----------------------------------------------------------------------------
// erhs_alu: shared add/subtract unit
// Carry out on add, borrow out on subtract.
// ----------------------------------------------------------------------------
module erhs_alu #(
  parameter int W = erhs_pkg::ALU_W
) (
  input  erhs_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              carry
);

  logic [W:0] sum;

  always_comb begin
    unique case (op)
      erhs_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      erhs_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default:           sum = '0;
    endcase
  end

  assign res   = sum[W-1:0];
  assign carry = sum[W];

endmodule

// ===== rtl/core/erhs_trap_mem.sv =====
// ----------------------------------------------------------------------------
// erhs_trap_mem: per-site trap time store
// One write port, one registered read port. Contents undefined until written.
// ----------------------------------------------------------------------------
module erhs_trap_mem #(
  parameter int DEPTH = erhs_pkg::MAX_SITES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [erhs_pkg::TRAP_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [erhs_pkg::TRAP_W-1:0] rdata
);

  logic [erhs_pkg::TRAP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/erhs_fsm.sv =====
// ----------------------------------------------------------------------------
// erhs_fsm: step sequencer
// Walks a step through the minimum search, clock update, subtract sweep, hop and redraw.
// ----------------------------------------------------------------------------
module erhs_fsm (
  input  logic            clk,
  input  logic            rst,
  input  erhs_pkg::stat_t stat,
  output erhs_pkg::ctrl_t ctrl
);

  erhs_pkg::state_t state;
  erhs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erhs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      erhs_pkg::ST_IDLE: begin
        if (stat.accept) begin
          unique case (stat.kind)
            erhs_pkg::KIND_STEP: state_next = erhs_pkg::ST_MIN;
            erhs_pkg::KIND_SEED:
              state_next = stat.seed_ok ? erhs_pkg::ST_POS : erhs_pkg::ST_DONE;
            default: state_next = erhs_pkg::ST_DONE;
          endcase
        end
      end
      erhs_pkg::ST_MIN: if (stat.cnt_last) state_next = erhs_pkg::ST_CLK;
      erhs_pkg::ST_CLK: state_next = erhs_pkg::ST_SUB;
      erhs_pkg::ST_SUB: if (stat.cnt_last) state_next = erhs_pkg::ST_POS;
      erhs_pkg::ST_POS:
        state_next = (stat.kind == erhs_pkg::KIND_STEP) ? erhs_pkg::ST_HOP
                                                        : erhs_pkg::ST_TRAP;
      erhs_pkg::ST_HOP:  state_next = erhs_pkg::ST_TRAP;
      erhs_pkg::ST_TRAP: state_next = erhs_pkg::ST_MUL;
      erhs_pkg::ST_MUL:  state_next = erhs_pkg::ST_WRW;
      erhs_pkg::ST_WRW:  state_next = erhs_pkg::ST_DONE;
      erhs_pkg::ST_DONE: if (stat.out_free) state_next = erhs_pkg::ST_IDLE;
      default:           state_next = erhs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.ready    = (state == erhs_pkg::ST_IDLE);
    ctrl.min_en   = (state == erhs_pkg::ST_MIN);
    ctrl.clk_en   = (state == erhs_pkg::ST_CLK);
    ctrl.sub_en   = (state == erhs_pkg::ST_SUB);
    ctrl.pos_en   = (state == erhs_pkg::ST_POS);
    ctrl.hop_en   = (state == erhs_pkg::ST_HOP);
    ctrl.trap_rd  = (state == erhs_pkg::ST_TRAP);
    ctrl.mul_en   = (state == erhs_pkg::ST_MUL);
    ctrl.wr_en    = (state == erhs_pkg::ST_WRW);
    ctrl.out_load = (state == erhs_pkg::ST_DONE) && stat.out_free;
  end

endmodule

// ===== rtl/core/exclusion_ring_hop_step_top.sv =====
// ----------------------------------------------------------------------------
// exclusion_ring_hop_step_top: kinetic Monte Carlo step of an exclusion ring
// Particle waits, sites, clock and current with a sequenced shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   items   - sink channel, one transaction per command (load trap time, step,
//             seed waiting time, clear clock and count).
//   results - source channel, exactly one transaction per command, in order.
//   cfg_we/cfg_index/cfg_data - register writes, for the user to make only
//             while the block idles; the block itself does not enforce it.
// Step sequence (P = particles in use): P compare passes, a clock add and P
// subtract passes through the one 48-bit adder, then hop, trap read, multiply
// and wait write. A seed does the site read, trap read, multiply and wait
// write only; load and clear go straight to the result register.
// Ready returns the cycle after the result register loads.
// A new command is taken once the previous one has reached the result
// register; that register holds its transaction until results.ready.
// A stalled receiver therefore holds the block after at most one more command.
// Reset: clock and count zero, waits zero, particle i at site i, ring size
// 100, 10 particles. Trap times are undefined until loaded.
// ----------------------------------------------------------------------------
module exclusion_ring_hop_step_top #(
  parameter int MAX_SITES     = erhs_pkg::MAX_SITES_DEF,
  parameter int MAX_PARTICLES = erhs_pkg::MAX_PARTICLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  erhs_chan_if.sink                       items,
  erhs_chan_if.source                     results,
  input  logic                            cfg_we,
  input  logic [erhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erhs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW  = $clog2(MAX_SITES);
  localparam int PW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int SIW = (SW > PW) ? SW : PW;
  localparam int LW  = $clog2(MAX_SITES + 1);
  localparam int PCW = $clog2(MAX_PARTICLES + 1);

  erhs_pkg::ctrl_t ctrl;
  erhs_pkg::stat_t stat;

  logic [erhs_pkg::RING_W-1:0]   ring_size;
  logic [erhs_pkg::PCOUNT_W-1:0] particle_count;

  logic [erhs_pkg::WAIT_W-1:0] wait_q [MAX_PARTICLES];
  logic [SIW-1:0]              site_q [MAX_PARTICLES];

  logic [erhs_pkg::CLOCK_W-1:0]        clock_total;
  logic signed [erhs_pkg::TALLY_W-1:0] current_tally;

  logic [erhs_pkg::KIND_W-1:0] kind_q;
  logic                        dir_q;
  logic [erhs_pkg::VAR_W-1:0]  variate_q;
  logic [LW-1:0]               eff_l;
  logic [PCW-1:0]              eff_p;
  logic [PW-1:0]               cnt;
  logic [PW-1:0]               m;
  logic [PW-1:0]               nb;
  logic [SIW-1:0]              pos;
  logic [SIW-1:0]              newpos;
  logic [SIW-1:0]              trap_addr;
  logic [erhs_pkg::WAIT_W-1:0] tmin;
  logic                        hopped;
  logic [erhs_pkg::PROD_W-1:0] product;

  logic                         accept;
  logic [31:0]                  l_calc;
  logic [31:0]                  p_calc;
  logic                         load_ok;
  logic                         seed_ok;
  logic [erhs_pkg::WAIT_W-1:0]  wait_rd;
  logic [PW-1:0]                site_ra;
  logic [SIW-1:0]               site_rd;
  logic [PW-1:0]                nb_calc;
  logic [SIW-1:0]               target;
  logic                         hop_ok;
  logic                         trap_oob;
  logic [erhs_pkg::TRAP_W-1:0]  trap_rd;
  logic [erhs_pkg::TRAP_W-1:0]  trap_use;
  erhs_pkg::alu_op_t            alu_op;
  logic [erhs_pkg::ALU_W-1:0]   alu_a;
  logic [erhs_pkg::ALU_W-1:0]   alu_b;
  logic [erhs_pkg::ALU_W-1:0]   alu_res;
  logic                         alu_carry;
  logic                         out_valid;
  erhs_pkg::out_item_t          out_data;

  assign items.ready   = ctrl.ready;
  assign accept        = items.valid && ctrl.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign load_ok = 32'(items.data.index) < 32'(MAX_SITES);
  assign seed_ok = 32'(items.data.index) < 32'(MAX_PARTICLES);

  assign stat.accept   = accept;
  assign stat.kind     = ctrl.ready ? items.data.kind : kind_q;
  assign stat.seed_ok  = seed_ok;
  assign stat.cnt_last = (32'(cnt) + 32'd1) >= 32'(eff_p);
  assign stat.out_free = !out_valid || results.ready;

  erhs_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Effective ring size and particle count
  always_comb begin
    l_calc = 32'(ring_size);
    if (l_calc < 32'd2) l_calc = 32'd2;
    if (l_calc > 32'(MAX_SITES)) l_calc = 32'(MAX_SITES);
    p_calc = 32'(particle_count);
    if (p_calc < 32'd1) p_calc = 32'd1;
    if (p_calc > 32'(MAX_PARTICLES)) p_calc = 32'(MAX_PARTICLES);
    if (p_calc > l_calc) p_calc = l_calc;
  end

  assign wait_rd = wait_q[cnt];
  assign site_ra = ctrl.hop_en ? nb : m;
  assign site_rd = site_q[site_ra];

  // Ring-order neighbour of the chosen particle
  always_comb begin
    if (!dir_q) begin
      nb_calc = (m == '0) ? PW'(32'(eff_p) - 32'd1) : m - PW'(1);
    end else begin
      nb_calc = ((32'(m) + 32'd1) >= 32'(eff_p)) ? '0 : m + PW'(1);
    end
  end

  // Hop target with wraparound; a stale site beyond the ring wraps too
  always_comb begin
    if (!dir_q) begin
      if (pos == '0 || 32'(pos) >= 32'(eff_l)) begin
        target = SIW'(32'(eff_l) - 32'd1);
      end else begin
        target = pos - SIW'(1);
      end
    end else begin
      target = (32'(pos) + 32'd1 >= 32'(eff_l)) ? '0 : pos + SIW'(1);
    end
  end

  assign hop_ok = (nb == m) || (site_rd != target);

  assign alu_op = ctrl.clk_en ? erhs_pkg::ALU_ADD : erhs_pkg::ALU_SUB;
  assign alu_a  = ctrl.clk_en ? clock_total : erhs_pkg::ALU_W'(wait_rd);
  assign alu_b  = erhs_pkg::ALU_W'(tmin);

  erhs_alu #(
    .W (erhs_pkg::ALU_W)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  erhs_trap_mem #(
    .DEPTH (MAX_SITES),
    .AW    (SW)
  ) u_trap_mem (
    .clk   (clk),
    .we    (accept && items.data.kind == erhs_pkg::KIND_LOAD && load_ok),
    .waddr (SW'(items.data.index)),
    .wdata (items.data.trap_value),
    .re    (ctrl.trap_rd),
    .raddr (trap_addr[SW-1:0]),
    .rdata (trap_rd)
  );

  assign trap_oob = 32'(trap_addr) >= 32'(MAX_SITES);
  assign trap_use = trap_oob ? '0 : trap_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size      <= erhs_pkg::RING_SIZE_RST;
      particle_count <= erhs_pkg::PCOUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        erhs_pkg::REG_RING_SIZE:      ring_size <= cfg_data;
        erhs_pkg::REG_PARTICLE_COUNT: particle_count <= cfg_data[erhs_pkg::PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PARTICLES; i++) begin
        wait_q[i] <= '0;
        site_q[i] <= SIW'(i);
      end
      clock_total   <= '0;
      current_tally <= '0;
      kind_q        <= erhs_pkg::KIND_LOAD;
      cnt           <= '0;
      m             <= '0;
      hopped        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        kind_q    <= items.data.kind;
        dir_q     <= items.data.direction;
        variate_q <= items.data.variate;
        eff_l     <= LW'(l_calc);
        eff_p     <= PCW'(p_calc);
        cnt       <= '0;
        hopped    <= 1'b0;
        if (items.data.kind == erhs_pkg::KIND_CLEAR) begin
          clock_total   <= '0;
          current_tally <= '0;
        end
        if (items.data.kind == erhs_pkg::KIND_SEED) begin
          m <= PW'(items.data.index);
        end
      end

      if (ctrl.min_en) begin
        if (cnt == '0) begin
          tmin <= wait_rd;
          m    <= '0;
        end else if (alu_carry) begin
          tmin <= wait_rd;
          m    <= cnt;
        end
        cnt <= stat.cnt_last ? '0 : cnt + PW'(1);
      end

      if (ctrl.clk_en) begin
        clock_total <= alu_carry ? '1 : alu_res;
      end

      if (ctrl.sub_en) begin
        wait_q[cnt] <= alu_res[erhs_pkg::WAIT_W-1:0];
        cnt         <= stat.cnt_last ? '0 : cnt + PW'(1);
      end

      if (ctrl.pos_en) begin
        pos       <= site_rd;
        newpos    <= site_rd;
        trap_addr <= site_rd;
        nb        <= nb_calc;
      end

      if (ctrl.hop_en && hop_ok) begin
        site_q[m] <= target;
        newpos    <= target;
        trap_addr <= target;
        hopped    <= 1'b1;
        if (!dir_q) begin
          if (current_tally != erhs_pkg::TALLY_MIN) current_tally <= current_tally - 1;
        end else begin
          if (current_tally != erhs_pkg::TALLY_MAX) current_tally <= current_tally + 1;
        end
      end

      if (ctrl.mul_en) begin
        product <= erhs_pkg::PROD_W'(trap_use) * erhs_pkg::PROD_W'(variate_q);
      end

      if (ctrl.wr_en) begin
        wait_q[m] <= erhs_pkg::WAIT_W'(product >> erhs_pkg::VAR_FRAC);
      end

      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data.elapsed_time <= clock_total;
      out_data.net_current  <= current_tally;
      out_data.hopped       <= hopped;
      if (kind_q == erhs_pkg::KIND_STEP) begin
        out_data.chosen_particle <= erhs_pkg::CHOSEN_W'(m);
        out_data.new_position    <= erhs_pkg::POS_W'(newpos);
      end else begin
        out_data.chosen_particle <= '0;
        out_data.new_position    <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_rise_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.out_load))
    else $error("result raised without a finished command");

  a_min_holds: assert property (@(posedge clk) disable iff (rst)
    ctrl.sub_en |-> !alu_carry)
    else $error("selected wait exceeds a particle wait");

  a_chosen_in_use: assert property (@(posedge clk) disable iff (rst)
    ctrl.hop_en |-> (32'(m) < 32'(eff_p)) && (32'(nb) < 32'(eff_p)))
    else $error("chosen particle or neighbour outside the particles in use");

  a_target_on_ring: assert property (@(posedge clk) disable iff (rst)
    ctrl.hop_en |-> 32'(target) < 32'(eff_l))
    else $error("hop target off the ring");
`endif

endmodule
